>>> design/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

    // Accumulator and digit geometry
    localparam int VALUE_BITS = 32;
    localparam int MAX_BASE   = 256;
    localparam int BASE_W     = 9;
    localparam int DIGIT_W    = 8;
    localparam int SLOTS      = VALUE_BITS;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int MBIT_W     = $clog2(BASE_W);

    // Configuration register indexes
    localparam logic REG_BASE_IN  = 1'b0;
    localparam logic REG_BASE_OUT = 1'b1;

    // Divider control and status
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Force a base register into the usable range [2, MAX_BASE]
    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_W'(2))
            r = BASE_W'(2);
        else if (b > BASE_W'(MAX_BASE))
            r = BASE_W'(MAX_BASE);
        else
            r = b;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/rdc_bit_divider.sv
// ----------------------------------------------------------------------------
// rdc_bit_divider
// Restoring divider, one quotient bit per cycle, VALUE_BITS quotient bits per divide.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_bit_divider (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rdc_pkg::div_ctl_t                ctl,
    input  wire logic [rdc_pkg::VALUE_BITS-1:0]   dividend,
    input  wire logic [rdc_pkg::BASE_W-1:0]       divisor,
    output rdc_pkg::div_sts_t                     sts,
    output logic      [rdc_pkg::VALUE_BITS-1:0]   quotient,
    output logic      [rdc_pkg::BASE_W-1:0]       remainder
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [rdc_pkg::BIT_W-1:0]        cnt_reg, cnt_next;
    logic [rdc_pkg::VALUE_BITS-1:0]   quot_reg, quot_next;
    logic [rdc_pkg::BASE_W-1:0]       rem_reg, rem_next;
    logic [rdc_pkg::BASE_W-1:0]       dvs_reg, dvs_next;
    logic [rdc_pkg::BASE_W:0]         trial;
    logic [rdc_pkg::BASE_W:0]         diff;
    logic                             ge;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quot_reg[rdc_pkg::VALUE_BITS-1]};
        ge    = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits BASE_W bits
            rem_next  = ge ? diff[rdc_pkg::BASE_W-1:0] : trial[rdc_pkg::BASE_W-1:0];
            quot_next = {quot_reg[rdc_pkg::VALUE_BITS-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == rdc_pkg::BIT_W'(rdc_pkg::VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> design/radix_digit_converter_core.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts a digit stream from one radix to another.
// ----------------------------------------------------------------------------
// Digits arrive on s_axis most significant first in radix base_in, tlast on
// the final digit; the number (32 bits, wrapping) is re-emitted on m_axis in
// radix base_out, most significant first, tlast on its final digit, and a
// zero number gives the single digit 0. Each input digit goes through a
// shift-add multiply over the 9 bits of base_in plus the digit add, and the
// input stays closed meanwhile. A final digit adds, per output digit, one
// bit-serial divide and its restart, and the buffered digits then leave one
// at a time through the EMIT and SHOW states when the sink is ready.
// Base registers are clamped to 2..256
// when used and must only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [rdc_pkg::BASE_W-1:0]    cfg_data,
    // input digits
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [7:0] digit_in
    input  wire logic                          s_axis_tlast,   // last_in
    // output digits
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [7:0]                    m_axis_tdata,   // [7:0] digit_out
    output logic                               m_axis_tlast    // last_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_SHOW = 3'd5;

    logic [2:0]                        state_reg, state_next;
    logic [rdc_pkg::BASE_W-1:0]        base_in_reg, base_out_reg;
    logic [rdc_pkg::VALUE_BITS-1:0]    value_reg, value_next;
    logic [rdc_pkg::VALUE_BITS-1:0]    prod_reg, prod_next;
    logic [rdc_pkg::MBIT_W-1:0]        mbit_reg, mbit_next;
    logic [rdc_pkg::DIGIT_W-1:0]       digit_reg, digit_next;
    logic                              last_reg, last_next;
    logic [rdc_pkg::SLOT_W-1:0]        n_reg, n_next;
    logic [rdc_pkg::SLOT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                              out_valid_reg, out_valid_next;
    logic [rdc_pkg::DIGIT_W-1:0]       out_digit_reg, out_digit_next;
    logic                              out_last_reg, out_last_next;
    logic [rdc_pkg::DIGIT_W-1:0]       mem_rd_reg;
    logic [rdc_pkg::DIGIT_W-1:0]       rem_buf [rdc_pkg::SLOTS];
    logic                              buf_we;

    logic [rdc_pkg::BASE_W-1:0]        bi_eff;
    logic [rdc_pkg::VALUE_BITS-1:0]    sum;
    logic                              in_acc;
    logic                              out_free;

    rdc_pkg::div_ctl_t                 div_ctl;
    rdc_pkg::div_sts_t                 div_sts;
    logic [rdc_pkg::VALUE_BITS-1:0]    div_dividend;
    logic [rdc_pkg::VALUE_BITS-1:0]    div_quot;
    logic [rdc_pkg::BASE_W-1:0]        div_rem;

    rdc_bit_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (rdc_pkg::clamp_base(base_out_reg)),
        .sts       (div_sts),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign bi_eff        = rdc_pkg::clamp_base(base_in_reg);
    assign sum           = prod_reg + rdc_pkg::VALUE_BITS'(digit_reg);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_in_reg  <= rdc_pkg::BASE_W'(2);
            base_out_reg <= rdc_pkg::BASE_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rdc_pkg::REG_BASE_IN:  base_in_reg  <= cfg_data;
                rdc_pkg::REG_BASE_OUT: base_out_reg <= cfg_data;
                default:               base_in_reg  <= base_in_reg;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        prod_next      = prod_reg;
        mbit_next      = mbit_reg;
        digit_next     = digit_reg;
        last_next      = last_reg;
        n_next         = n_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_digit_next = out_digit_reg;
        out_last_next  = out_last_reg;
        div_ctl.start  = 1'b0;
        div_dividend   = div_quot;
        buf_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    digit_next = s_axis_tdata;
                    last_next  = s_axis_tlast;
                    prod_next  = '0;
                    mbit_next  = rdc_pkg::MBIT_W'(rdc_pkg::BASE_W - 1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // shift-add over base bits, most significant first
                prod_next = {prod_reg[rdc_pkg::VALUE_BITS-2:0], 1'b0}
                          + (bi_eff[mbit_reg] ? value_reg : '0);
                mbit_next = mbit_reg - 1'b1;
                if (mbit_reg == '0)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (last_reg)
                begin
                    value_next    = '0;
                    n_next        = '0;
                    div_dividend  = sum;
                    div_ctl.start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    value_next = sum;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    buf_we = 1'b1;
                    if ((div_quot != '0) && (n_reg != rdc_pkg::SLOT_W'(rdc_pkg::SLOTS - 1)))
                    begin
                        n_next        = n_reg + 1'b1;
                        div_ctl.start = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = n_reg;
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_digit_next = mem_rd_reg;
                    out_last_next  = (rd_idx_reg == '0);
                    if (rd_idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = ST_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            rd_idx_reg    <= '0;
            mbit_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            value_reg     <= value_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            rd_idx_reg    <= rd_idx_next;
            mbit_reg      <= mbit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        digit_reg     <= digit_next;
        last_reg      <= last_next;
        out_digit_reg <= out_digit_next;
        out_last_reg  <= out_last_next;
    end

    // Remainder buffer, least significant digit at slot 0
    always_ff @(posedge clk)
    begin
        if (buf_we)
            rem_buf[n_reg] <= div_rem[rdc_pkg::DIGIT_W-1:0];
        if (state_reg == ST_EMIT)
            mem_rd_reg <= rem_buf[rd_idx_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_digit_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> design/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks for the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    // a stalled output transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // no input is taken while a number is still being emitted
    a_no_in_mid_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready while emitting a non-final digit");

    // every accepted digit keeps the input closed for the multiply
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted digit");

    // output is quiet on the edge after reset has been seen
    a_rst_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radix_digit_converter_core: digits of random numbers
// in one radix go in on s_axis, and each digit coming out on m_axis is checked
// against a digit list that the bench computes itself for every number.
// ----------------------------------------------------------------------------

module tb;

    // One expected output digit
    typedef struct packed {
        logic [rdc_pkg::DIGIT_W-1:0] digit;
        logic                        last;
    } out_digit_t;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       cfg_we        = 1'b0;
    logic                       cfg_index     = rdc_pkg::REG_BASE_IN;
    logic [rdc_pkg::BASE_W-1:0] cfg_data      = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata  = '0;   // [7:0] digit_in
    logic                       s_axis_tlast  = 1'b0; // last_in
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [7:0]                 m_axis_tdata;         // [7:0] digit_out
    logic                       m_axis_tlast;         // last_out

    // Bench copy of the block state
    logic [rdc_pkg::BASE_W-1:0]     radix_in_q  = rdc_pkg::BASE_W'(2);
    logic [rdc_pkg::BASE_W-1:0]     radix_out_q = rdc_pkg::BASE_W'(10);
    logic [rdc_pkg::VALUE_BITS-1:0] acc_value   = '0;
    out_digit_t                     pending_digits[$];

    int mismatches = 0;
    int burst_left = 0;
    int sent_items = 0;

    radix_digit_converter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #50_000_000;
        $display("tb NOT OK");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // Radix actually used for a register value
    function automatic logic [rdc_pkg::BASE_W-1:0] usable_radix(
        input logic [rdc_pkg::BASE_W-1:0] r);
        if (r < rdc_pkg::BASE_W'(2))
            return rdc_pkg::BASE_W'(2);
        if (r > rdc_pkg::BASE_W'(rdc_pkg::MAX_BASE))
            return rdc_pkg::BASE_W'(rdc_pkg::MAX_BASE);
        return r;
    endfunction

    // Fold one accepted digit in; on the final digit queue the converted digits
    task automatic fold_digit(input logic [7:0] d, input logic fin);
        logic [63:0]                    wide;
        logic [rdc_pkg::VALUE_BITS-1:0] v;
        logic [rdc_pkg::VALUE_BITS-1:0] ro;
        logic [rdc_pkg::DIGIT_W-1:0]    rems[$];
        out_digit_t                     od;
        int                             n;
        wide = 64'(acc_value) * 64'(usable_radix(radix_in_q)) + 64'(d);
        acc_value = wide[rdc_pkg::VALUE_BITS-1:0];
        if (!fin)
            return;
        v  = acc_value;
        ro = rdc_pkg::VALUE_BITS'(usable_radix(radix_out_q));
        if (v == '0)
            rems.insert(rems.size(), rdc_pkg::DIGIT_W'(0));
        while (v != '0 && rems.size() < rdc_pkg::SLOTS)
        begin
            rems.insert(rems.size(), rdc_pkg::DIGIT_W'(v % ro));
            v = v / ro;
        end
        // remainders come least significant first; expect most significant first
        n = rems.size();
        for (int k = n - 1; k >= 0; k--)
        begin
            od.digit = rems[k];
            od.last  = (k == 0);
            pending_digits.insert(pending_digits.size(), od);
        end
        acc_value = '0;
    endtask

    // Send one input transaction; the sender works in bursts with gaps between
    task automatic send_digit(input logic [7:0] d, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        fold_digit(d, fin);
        sent_items++;
    endtask

    // Hold off the sender until every expected digit has come out
    task automatic settle_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Register write; only called while the block is idle
    task automatic write_radix(input logic idx, input logic [rdc_pkg::BASE_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == rdc_pkg::REG_BASE_IN)
            radix_in_q = val;
        else
            radix_out_q = val;
    endtask

    task automatic set_radices(input logic [rdc_pkg::BASE_W-1:0] rin,
                               input logic [rdc_pkg::BASE_W-1:0] rout);
        settle_idle();
        write_radix(rdc_pkg::REG_BASE_IN, rin);
        write_radix(rdc_pkg::REG_BASE_OUT, rout);
    endtask

    // Receiver: ready pattern switches between always ready, light and heavy stalls
    int ready_mode = 0;
    int ready_left = 0;
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(20, 200);
        end
        ready_left--;
        case (ready_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Check every output transaction against the oldest expected digit
    always @(posedge clk)
    begin : check_out
        out_digit_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_digits.size() == 0)
                flag_mismatch($sformatf("unexpected digit %0d last %0b",
                                        m_axis_tdata, m_axis_tlast));
            else
            begin
                want = pending_digits.pop_front();
                if (m_axis_tdata !== want.digit)
                    flag_mismatch($sformatf("digit_out %0d, expected %0d",
                                            m_axis_tdata, want.digit));
                if (m_axis_tlast !== want.last)
                    flag_mismatch($sformatf("last_out %0b, expected %0b",
                                            m_axis_tlast, want.last));
            end
        end
    end

    // Reset values of the radix registers, and a zero number
    task automatic test_reset_radices();
        send_digit(8'd1, 1'b0);
        send_digit(8'd0, 1'b0);
        send_digit(8'd1, 1'b0);
        send_digit(8'd1, 1'b1);
        send_digit(8'd0, 1'b1);
    endtask

    // Widest digits, longest output, wrap and out-of-range digits
    task automatic test_extremes();
        set_radices(rdc_pkg::BASE_W'(256), rdc_pkg::BASE_W'(256));
        repeat (3) send_digit(8'hFF, 1'b0);
        send_digit(8'hFF, 1'b1);
        // all-ones value in radix 2 gives the longest digit run
        set_radices(rdc_pkg::BASE_W'(256), rdc_pkg::BASE_W'(2));
        repeat (3) send_digit(8'hFF, 1'b0);
        send_digit(8'hFF, 1'b1);
        // five radix-256 digits overflow the accumulator
        set_radices(rdc_pkg::BASE_W'(256), rdc_pkg::BASE_W'(16));
        send_digit(8'h01, 1'b0);
        repeat (3) send_digit(8'hFF, 1'b0);
        send_digit(8'hFF, 1'b1);
        // digit not below the input radix
        set_radices(rdc_pkg::BASE_W'(10), rdc_pkg::BASE_W'(10));
        send_digit(8'd255, 1'b0);
        send_digit(8'd9, 1'b1);
    endtask

    // Register values outside 2..256 are clamped when used
    task automatic test_radix_clamp();
        set_radices(rdc_pkg::BASE_W'(0), rdc_pkg::BASE_W'(511));
        send_digit(8'd1, 1'b0);
        send_digit(8'd1, 1'b1);
        set_radices(rdc_pkg::BASE_W'(511), rdc_pkg::BASE_W'(1));
        send_digit(8'd1, 1'b0);
        send_digit(8'd0, 1'b1);
        set_radices(rdc_pkg::BASE_W'(257), rdc_pkg::BASE_W'(3));
        send_digit(8'd200, 1'b1);
    endtask

    function automatic logic [rdc_pkg::BASE_W-1:0] pick_radix();
        case ($urandom_range(0, 9))
            0:       return rdc_pkg::BASE_W'($urandom_range(0, 511));
            1:       return rdc_pkg::BASE_W'(2);
            2:       return rdc_pkg::BASE_W'(256);
            default: return rdc_pkg::BASE_W'($urandom_range(2, 256));
        endcase
    endfunction

    // Random numbers over a series of radix settings
    task automatic test_random_numbers();
        int                         phase;
        int                         numbers;
        int                         len;
        int                         top;
        logic [rdc_pkg::BASE_W-1:0] rin;
        logic [rdc_pkg::BASE_W-1:0] rout;
        logic [7:0]                 d;
        phase = 0;
        while (sent_items < 240)
        begin
            case (phase)
                0:
                begin
                    rin  = rdc_pkg::BASE_W'(2);
                    rout = rdc_pkg::BASE_W'(2);
                end
                1:
                begin
                    rin  = rdc_pkg::BASE_W'(256);
                    rout = rdc_pkg::BASE_W'(256);
                end
                2:
                begin
                    rin  = rdc_pkg::BASE_W'(2);
                    rout = rdc_pkg::BASE_W'(256);
                end
                3:
                begin
                    rin  = rdc_pkg::BASE_W'(256);
                    rout = rdc_pkg::BASE_W'(2);
                end
                default:
                begin
                    rin  = pick_radix();
                    rout = pick_radix();
                end
            endcase
            set_radices(rin, rout);
            top = int'(usable_radix(rin)) - 1;
            numbers = $urandom_range(2, 6);
            repeat (numbers)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10)
                                                  : $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                begin
                    // mostly digits valid for the radix, sometimes any byte
                    if ($urandom_range(0, 7) == 0)
                        d = 8'($urandom_range(0, 255));
                    else
                        d = 8'($urandom_range(0, top));
                    send_digit(d, i == len - 1);
                end
            end
            phase++;
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_reset_radices();
        test_extremes();
        test_radix_clamp();
        test_random_numbers();

        settle_idle();
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
